[hw/rtl/ffpa_pkg.sv]
package ffpa_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_DECIDE,
        S_EDIT,
        S_DONE
    } state_t;

    // Request modes (code 3 is unused)
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NO_SPACE   = 2'd1;
    localparam logic [1:0] STAT_BAD_ADDR   = 2'd2;
    localparam logic [1:0] STAT_TABLE_FULL = 2'd3;

    // Field widths
    localparam int REQ_W   = 32;
    localparam int ADDR_W  = 25;
    localparam int BYTES_W = 26;

    // Divider control
    typedef struct packed {
        logic start;
    } div_ctl_t;

endpackage

[hw/rtl/ffpa_cell.sv]
module ffpa_cell #(
    parameter int SW         = 15,
    parameter bit INIT_VALID = 1'b0,
    parameter int INIT_START = 0,
    parameter int INIT_UNITS = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic          d_valid,
    input  logic [SW-1:0] d_start,
    input  logic [SW-1:0] d_units,
    output logic          q_valid,
    output logic [SW-1:0] q_start,
    output logic [SW-1:0] q_units
);

    logic          valid_reg;
    logic [SW-1:0] start_reg;
    logic [SW-1:0] units_reg;

    // One extent slot; takes its neighbour's entry on every shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= INIT_VALID;
            start_reg <= SW'(INIT_START);
            units_reg <= SW'(INIT_UNITS);
        end
        else if (shift)
        begin
            valid_reg <= d_valid;
            start_reg <= d_start;
            units_reg <= d_units;
        end
    end

    assign q_valid = valid_reg;
    assign q_start = start_reg;
    assign q_units = units_reg;

endmodule

[hw/rtl/ffpa_div.sv]
module ffpa_div #(
    parameter int DW      = 34,
    parameter int DIVISOR = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ffpa_pkg::div_ctl_t                  ctl_in,
    input  logic [DW-1:0]                       dividend,
    output logic                                done,
    output logic [DW-1:0]                       quotient,
    output logic [$clog2(DIVISOR+1):0]          remainder
);
    import ffpa_pkg::*;

    localparam int RW = $clog2(DIVISOR + 1) + 1;
    localparam int SH = $clog2(DIVISOR);

    logic          done_reg;
    logic [DW-1:0] num_reg;
    logic [RW-1:0] rem_reg;

    // Result is ready in the cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_in.start;
    end

    // Divisor is a power of two: shift for the quotient, mask for the remainder
    always_ff @(posedge clk)
    begin
        if (ctl_in.start)
        begin
            num_reg <= dividend >> SH;
            rem_reg <= RW'(dividend[SH-1:0]);
        end
    end

    assign done      = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/first_fit_pool_allocator_unit.sv]
// First-fit pool allocator. Hands out whole units of a pool (unit 0 reserved),
// keeps the free extents in a rotating row of MAX_EXTENTS cells ordered by
// start unit, and merges freed blocks with touching neighbours. UNIT_BYTES is
// taken to be a power of two. One request is worked at a time: a shift and
// mask by UNIT_BYTES, one full rotation of the cell row to search, a decide
// step, a second rotation to apply the edit, then the result beat. A new
// request is not taken until the last one has reached the result register; a
// result that is still held back when the next one is ready delays it. After
// reset a clearing pass zeroes every entry of the allocation mark memory;
// s_tready stays low until it is done. A new request is taken while a result
// still waits.
module first_fit_pool_allocator_unit #(
    parameter int POOL_UNITS   = 32768,
    parameter int UNIT_BYTES   = 1024,
    parameter int HEADER_BYTES = 12,
    parameter int MAX_EXTENTS  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // request_bytes[31:0], address[56:32], zero fill
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // block_address[24:0], block_bytes[50:25],
                                  // free_bytes[76:51], zero fill
    output logic [1:0]  m_tuser   // status[1:0]
);
    import ffpa_pkg::*;

    localparam int SW = $clog2(POOL_UNITS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int KW = $clog2(MAX_EXTENTS);
    localparam int DW = 34;
    localparam int RW = $clog2(UNIT_BYTES + 1) + 1;
    localparam logic [63:0] FREE_INIT = 64'(POOL_UNITS - 1) * 64'(UNIT_BYTES);

    state_t state_reg, state_next;

    // Input fields
    logic [REQ_W-1:0]  in_req;
    logic [ADDR_W-1:0] in_addr;
    assign in_req  = s_tdata[31:0];
    assign in_addr = s_tdata[56:32];

    // Control strobes
    logic     accept, shift, out_load, mem_we;
    div_ctl_t div_ctl;
    logic     div_done;
    logic [DW-1:0] div_q;
    logic [RW-1:0] div_r;
    logic [DW-1:0] dividend;

    // Request registers
    logic [1:0]    mode_reg;
    logic          addr_ge_reg;
    logic [SW-1:0] clr_cnt_reg;
    logic [KW-1:0] k_reg;
    logic [CW-1:0] count_reg;
    logic [BYTES_W-1:0] free_reg;

    // Scan results
    logic          fnd_reg, pv_reg;
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] f_start_reg, f_units_reg;
    logic [SW:0]   pv_end_reg;
    logic [SW-1:0] pv_units_reg;

    // Edit plan
    logic          mod_en_reg, del_en_reg, ins_en_reg;
    logic [CW-1:0] mod_idx_reg, del_idx_reg, ins_idx_reg;
    logic [SW-1:0] mod_start_reg, mod_units_reg;
    logic [SW-1:0] ins_start_reg, ins_units_reg;
    logic          h_valid_reg;
    logic [SW-1:0] h_start_reg, h_units_reg;

    // Result plan
    logic [1:0]    stat_reg;
    logic [SW-1:0] res_n_reg, res_blk_reg;
    logic          mark_we_reg;
    logic [SW-1:0] mark_addr_reg, mark_data_reg;
    logic [CW-1:0] count_new_reg;
    logic [47:0]        prod_bytes, prod_addr;
    logic [BYTES_W-1:0] res_bytes;

    // Mark memory
    logic [SW-1:0] mark_mem [POOL_UNITS];
    logic [SW-1:0] mark_rd_reg;
    logic [SW-1:0] mem_wa, mem_wd;

    // Cell row
    logic          c_valid [MAX_EXTENTS];
    logic [SW-1:0] c_start [MAX_EXTENTS];
    logic [SW-1:0] c_units [MAX_EXTENTS];
    logic          e_valid;
    logic [SW-1:0] e_start, e_units;

    // Output register
    logic              m_valid_reg;
    logic [1:0]        o_stat_reg;
    logic [ADDR_W-1:0] o_addr_reg;
    logic [BYTES_W-1:0] o_bytes_reg;

    // Request decode
    logic [SW-1:0] u_idx;
    logic          u_ok;
    assign u_idx = div_q[SW-1:0];
    assign u_ok  = addr_ge_reg && (div_r == '0) && (div_q != '0) &&
                   (div_q < DW'(POOL_UNITS));

    always_comb
    begin
        if (s_tuser == MODE_ALLOC)
            dividend = DW'(in_req) + DW'(HEADER_BYTES) + DW'(UNIT_BYTES - 1);
        else
            dividend = DW'(in_addr) - DW'(HEADER_BYTES);
    end

    ffpa_div #(.DW(DW), .DIVISOR(UNIT_BYTES)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (div_ctl),
        .dividend  (dividend),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Cell row: cell k takes from cell k+1, the last from the edit unit
    genvar g;
    generate
        for (g = 0; g < MAX_EXTENTS; g++)
        begin : g_cell
            logic          dv;
            logic [SW-1:0] ds, du;
            if (g == MAX_EXTENTS - 1)
            begin : g_tail
                assign dv = e_valid;
                assign ds = e_start;
                assign du = e_units;
            end
            else
            begin : g_body
                assign dv = c_valid[g+1];
                assign ds = c_start[g+1];
                assign du = c_units[g+1];
            end
            ffpa_cell #(
                .SW         (SW),
                .INIT_VALID (g == 0),
                .INIT_START ((g == 0) ? 1 : 0),
                .INIT_UNITS ((g == 0) ? POOL_UNITS - 1 : 0)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .shift   (shift),
                .d_valid (dv),
                .d_start (ds),
                .d_units (du),
                .q_valid (c_valid[g]),
                .q_start (c_start[g]),
                .q_units (c_units[g])
            );
        end
    endgenerate

    // Edit unit at the row's head
    logic [CW-1:0] kx;
    assign kx = CW'(k_reg);

    always_comb
    begin
        e_valid = c_valid[0];
        e_start = c_start[0];
        e_units = c_units[0];
        if (state_reg == S_EDIT)
        begin
            if (ins_en_reg && kx > ins_idx_reg)
            begin
                e_valid = h_valid_reg;
                e_start = h_start_reg;
                e_units = h_units_reg;
            end
            else if (ins_en_reg && kx == ins_idx_reg)
            begin
                e_valid = 1'b1;
                e_start = ins_start_reg;
                e_units = ins_units_reg;
            end
            else if (del_en_reg && kx >= del_idx_reg)
            begin
                if (k_reg == KW'(MAX_EXTENTS - 1))
                begin
                    e_valid = 1'b0;
                    e_start = '0;
                    e_units = '0;
                end
                else
                begin
                    e_valid = c_valid[1];
                    e_start = c_start[1];
                    e_units = c_units[1];
                end
            end
            else if (mod_en_reg && kx == mod_idx_reg)
            begin
                e_valid = 1'b1;
                e_start = mod_start_reg;
                e_units = mod_units_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EDIT)
        begin
            h_valid_reg <= c_valid[0];
            h_start_reg <= c_start[0];
            h_units_reg <= c_units[0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  if (clr_cnt_reg == SW'(POOL_UNITS - 1)) state_next = S_IDLE;
            S_IDLE:   if (s_tvalid) state_next = S_DIV;
            S_DIV:    if (div_done) state_next = S_SCAN;
            S_SCAN:   if (k_reg == KW'(MAX_EXTENTS - 1)) state_next = S_DECIDE;
            S_DECIDE: state_next = S_EDIT;
            S_EDIT:   if (k_reg == KW'(MAX_EXTENTS - 1)) state_next = S_DONE;
            S_DONE:   if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready      = (state_reg == S_IDLE);
        accept        = (state_reg == S_IDLE) && s_tvalid;
        div_ctl.start = accept;
        shift         = (state_reg == S_SCAN) || (state_reg == S_EDIT);
        out_load      = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
        mem_we        = (state_reg == S_CLEAR) || (out_load && mark_we_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            k_reg       <= '0;
            count_reg   <= CW'(1);
            free_reg    <= BYTES_W'(FREE_INIT);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (shift)
                k_reg <= (k_reg == KW'(MAX_EXTENTS - 1)) ? '0 : k_reg + 1'b1;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                count_reg   <= count_new_reg;
                if (stat_reg == STAT_OK && mode_reg == MODE_ALLOC)
                    free_reg <= free_reg - res_bytes;
                else if (stat_reg == STAT_OK && mode_reg == MODE_FREE)
                    free_reg <= free_reg + res_bytes;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Mark memory: one write port, registered read
    assign mem_wa = (state_reg == S_CLEAR) ? clr_cnt_reg : mark_addr_reg;
    assign mem_wd = (state_reg == S_CLEAR) ? '0 : mark_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mark_mem[mem_wa] <= mem_wd;
        mark_rd_reg <= mark_mem[u_idx];
    end

    // Request capture and scan
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= s_tuser;
            addr_ge_reg <= (in_addr >= ADDR_W'(HEADER_BYTES));
            fnd_reg     <= 1'b0;
            pv_reg      <= 1'b0;
        end
        else if (state_reg == S_SCAN && c_valid[0] && !fnd_reg)
        begin
            if (mode_reg == MODE_ALLOC)
            begin
                if (DW'(c_units[0]) >= div_q)
                begin
                    fnd_reg     <= 1'b1;
                    idx_reg     <= kx;
                    f_start_reg <= c_start[0];
                    f_units_reg <= c_units[0];
                end
            end
            else if (c_start[0] > u_idx)
            begin
                fnd_reg     <= 1'b1;
                idx_reg     <= kx;
                f_start_reg <= c_start[0];
                f_units_reg <= c_units[0];
            end
            else
            begin
                pv_reg       <= 1'b1;
                pv_end_reg   <= {1'b0, c_start[0]} + {1'b0, c_units[0]};
                pv_units_reg <= c_units[0];
            end
        end
    end

    // Decide: turn the scan into an edit plan and a result
    logic [CW-1:0] ins_at;
    logic          jp, jn;
    logic [SW-1:0] need_u;
    assign ins_at = fnd_reg ? idx_reg : count_reg;
    assign jp     = pv_reg && (pv_end_reg == {1'b0, u_idx});
    assign jn     = fnd_reg && (({1'b0, u_idx} + {1'b0, mark_rd_reg}) == {1'b0, f_start_reg});
    assign need_u = div_q[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECIDE)
        begin
            mod_en_reg    <= 1'b0;
            del_en_reg    <= 1'b0;
            ins_en_reg    <= 1'b0;
            mark_we_reg   <= 1'b0;
            stat_reg      <= STAT_BAD_ADDR;
            res_n_reg     <= '0;
            res_blk_reg   <= '0;
            count_new_reg <= count_reg;
            mod_idx_reg   <= ins_at - 1'b1;
            del_idx_reg   <= ins_at;
            ins_idx_reg   <= ins_at;
            mod_start_reg <= f_start_reg;
            mod_units_reg <= f_units_reg - need_u;
            ins_start_reg <= u_idx;
            ins_units_reg <= mark_rd_reg;
            mark_addr_reg <= u_idx;
            mark_data_reg <= '0;
            case (mode_reg)
                MODE_ALLOC:
                begin
                    if (!fnd_reg)
                        stat_reg <= STAT_NO_SPACE;
                    else
                    begin
                        stat_reg      <= STAT_OK;
                        res_n_reg     <= need_u;
                        mark_we_reg   <= 1'b1;
                        mark_data_reg <= need_u;
                        if (f_units_reg == need_u)
                        begin
                            del_en_reg    <= 1'b1;
                            count_new_reg <= count_reg - 1'b1;
                            res_blk_reg   <= f_start_reg;
                            mark_addr_reg <= f_start_reg;
                        end
                        else
                        begin
                            mod_en_reg    <= 1'b1;
                            mod_idx_reg   <= idx_reg;
                            res_blk_reg   <= f_start_reg + f_units_reg - need_u;
                            mark_addr_reg <= f_start_reg + f_units_reg - need_u;
                        end
                    end
                end
                MODE_FREE:
                begin
                    if (u_ok && mark_rd_reg != '0)
                    begin
                        if (!jp && !jn && count_reg >= CW'(MAX_EXTENTS))
                            stat_reg <= STAT_TABLE_FULL;
                        else
                        begin
                            stat_reg    <= STAT_OK;
                            res_n_reg   <= mark_rd_reg;
                            mark_we_reg <= 1'b1;
                            if (jp && jn)
                            begin
                                mod_en_reg    <= 1'b1;
                                mod_start_reg <= pv_end_reg[SW-1:0] - pv_units_reg;
                                mod_units_reg <= pv_units_reg + mark_rd_reg + f_units_reg;
                                del_en_reg    <= 1'b1;
                                count_new_reg <= count_reg - 1'b1;
                            end
                            else if (jp)
                            begin
                                mod_en_reg    <= 1'b1;
                                mod_start_reg <= pv_end_reg[SW-1:0] - pv_units_reg;
                                mod_units_reg <= pv_units_reg + mark_rd_reg;
                            end
                            else if (jn)
                            begin
                                mod_en_reg    <= 1'b1;
                                mod_idx_reg   <= idx_reg;
                                mod_start_reg <= u_idx;
                                mod_units_reg <= f_units_reg + mark_rd_reg;
                            end
                            else
                            begin
                                ins_en_reg    <= 1'b1;
                                count_new_reg <= count_reg + 1'b1;
                            end
                        end
                    end
                end
                MODE_QUERY:
                begin
                    if (u_ok && mark_rd_reg != '0)
                    begin
                        stat_reg  <= STAT_OK;
                        res_n_reg <= mark_rd_reg;
                    end
                end
                default:
                begin
                    stat_reg <= STAT_BAD_ADDR;
                end
            endcase
        end
    end

    // Result scaling
    assign prod_bytes = 48'(res_n_reg) * 48'(UNIT_BYTES);
    assign prod_addr  = 48'(res_blk_reg) * 48'(UNIT_BYTES) + 48'(HEADER_BYTES);
    assign res_bytes  = prod_bytes[BYTES_W-1:0];

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_stat_reg  <= stat_reg;
            o_bytes_reg <= (stat_reg == STAT_OK) ? res_bytes : '0;
            o_addr_reg  <= (stat_reg == STAT_OK && mode_reg == MODE_ALLOC) ?
                           prod_addr[ADDR_W-1:0] : '0;
        end
    end

    // Result free total reflects this item
    logic [BYTES_W-1:0] free_out_reg;
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (stat_reg == STAT_OK && mode_reg == MODE_ALLOC)
                free_out_reg <= free_reg - res_bytes;
            else if (stat_reg == STAT_OK && mode_reg == MODE_FREE)
                free_out_reg <= free_reg + res_bytes;
            else
                free_out_reg <= free_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_stat_reg;
    assign m_tdata  = {3'b000, free_out_reg, o_bytes_reg, o_addr_reg};

endmodule

[hw/rtl/ffpa_checker.sv]
module ffpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import ffpa_pkg::*;

    // A result beat that is held back keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // One request in flight: no second beat right after an accepted one
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while one is still in work");

    // Failed requests report no block size
    a_err_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[50:25] == '0)
        else $error("non-zero size on a failed request");

    // A block address only comes with a good allocation
    a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24:0] != '0 |-> m_tuser == STAT_OK)
        else $error("block address on a failed request");

endmodule

bind first_fit_pool_allocator_unit ffpa_checker u_ffpa_checker (.*);
